// File: hw/rtl/rlsa_pkg.sv
// ----------------------------------------------------------------------------
// rlsa_pkg
// Shared widths, codes and reset values for the steering actuator step.
// ----------------------------------------------------------------------------
package rlsa_pkg;

  localparam int DATA_W = 32;
  localparam int RATE_W = 31;
  localparam int STEP_W = 25;
  localparam int CASE_W = 2;
  localparam int IDX_W  = 3;

  localparam logic signed [DATA_W-1:0] MIN_STEER_ANGLE_DEF = -32'sd8388608;
  localparam logic signed [DATA_W-1:0] MAX_STEER_ANGLE_DEF = 32'sd8388608;

  typedef enum logic [IDX_W-1:0] {
    REG_A11  = 3'd0,
    REG_A12  = 3'd1,
    REG_A21  = 3'd2,
    REG_A22  = 3'd3,
    REG_B1   = 3'd4,
    REG_B2   = 3'd5,
    REG_RATE = 3'd6,
    REG_STEP = 3'd7
  } reg_idx_t;

  typedef enum logic [CASE_W-1:0] {
    CASE_LINEAR = 2'd0,
    CASE_WHOLE  = 2'd1,
    CASE_MID    = 2'd2
  } limit_case_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] angle_request;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] angle_out;
    logic signed [DATA_W-1:0] rate_out;
    logic [CASE_W-1:0]        limit_case;
  } out_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;
  } cfg_word_t;

endpackage

// File: hw/rtl/rlsa_if.sv
// ----------------------------------------------------------------------------
// rlsa_if
// Valid/ready channel carrying one word.
// ----------------------------------------------------------------------------
interface rlsa_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/rate_limited_steering_actuator_step.sv
// ----------------------------------------------------------------------------
// rate_limited_steering_actuator_step
// One control step of a rate limited second-order steering actuator.
// ----------------------------------------------------------------------------
// One word is processed at a time. Multiplies are shift-add, one multiplier
// bit per cycle (six for the linear update, up to three for the limited
// cases), and the divide is restoring, one quotient bit per cycle. The next
// word is accepted once the result register is free.
module rate_limited_steering_actuator_step #(
  parameter logic signed [31:0] MIN_STEER_ANGLE = rlsa_pkg::MIN_STEER_ANGLE_DEF,
  parameter logic signed [31:0] MAX_STEER_ANGLE = rlsa_pkg::MAX_STEER_ANGLE_DEF
) (
  input  logic clk,
  input  logic rst_n,
  rlsa_if.sink   in_ch,
  rlsa_if.source out_ch,
  rlsa_if.sink   cfg_ch
);
  import rlsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_LIN, S_DEC, S_DIV, S_MAG, S_DONE
  } state_t;

  state_t state_r;
  logic signed [31:0] c_r [6];
  logic [30:0] max_rate_r;
  logic [24:0] step_r;
  logic signed [31:0] ang_r, rat_r, req_r;
  logic signed [31:0] lin_a_r, lin_r_r;
  logic [2:0]  mi_r;       // multiply index
  logic [4:0]  bit_r;
  logic [5:0]  dbit_r;
  logic signed [65:0] acc_r;
  logic [63:0] mcand_r;    // magnitude multiplicand
  logic [31:0] mplier_r;
  logic        neg_r;
  logic [63:0] num_r, quo_r, den_r;
  logic [64:0] rem_r;
  logic [1:0]  mode_r;
  logic [31:0] abs_old_r;
  logic [63:0] tacc_r, s_r;
  logic        out_v_r;
  out_word_t   out_r;

  assign in_ch.ready  = (state_r == S_IDLE) && !out_v_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  function automatic logic signed [31:0] sat(input logic signed [65:0] x);
    logic signed [65:0] r;
    r = x >>> 24;
    if (r > 66'sd2147483647) return 32'sh7fffffff;
    if (r < -66'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

  logic signed [31:0] mc_sel, mx_sel;
  always_comb begin
    case (mi_r)
      3'd0: begin mc_sel = c_r[0]; mx_sel = ang_r; end
      3'd1: begin mc_sel = c_r[1]; mx_sel = rat_r; end
      3'd2: begin mc_sel = c_r[4]; mx_sel = req_r; end
      3'd3: begin mc_sel = c_r[2]; mx_sel = ang_r; end
      3'd4: begin mc_sel = c_r[3]; mx_sel = rat_r; end
      default: begin mc_sel = c_r[5]; mx_sel = req_r; end
    endcase
  end

  logic [31:0] abs_lin;
  logic [64:0] rem_sh;
  logic signed [33:0] na;
  always_comb begin
    abs_lin = lin_r_r[31] ? 32'(-lin_r_r) : lin_r_r;
    rem_sh  = {rem_r[63:0], num_r[63]};
    na = {{2{ang_r[31]}}, ang_r};
  end

  logic signed [33:0] newa;
  always_comb begin
    newa = neg_r ? na - $signed({2'b00, s_r[31:0]}) : na + $signed({2'b00, s_r[31:0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
      c_r[0] <= 32'sd16777216; c_r[1] <= '0; c_r[2] <= '0;
      c_r[3] <= 32'sd16777216; c_r[4] <= '0; c_r[5] <= '0;
      max_rate_r <= 31'd167772160;
      step_r <= 25'd167772;
      ang_r <= '0;
      rat_r <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_v_r <= 1'b0;
      if (cfg_ch.valid) begin
        case (reg_idx_t'(cfg_ch.data.index))
          REG_A11:  c_r[0] <= cfg_ch.data.data;
          REG_A12:  c_r[1] <= cfg_ch.data.data;
          REG_A21:  c_r[2] <= cfg_ch.data.data;
          REG_A22:  c_r[3] <= cfg_ch.data.data;
          REG_B1:   c_r[4] <= cfg_ch.data.data;
          REG_B2:   c_r[5] <= cfg_ch.data.data;
          REG_RATE: max_rate_r <= cfg_ch.data.data[30:0];
          REG_STEP: step_r <= cfg_ch.data.data[24:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            req_r <= in_ch.data.angle_request;
            mi_r <= '0;
            bit_r <= '0;
            acc_r <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          // acc += sign-extended c * bit of x (two's complement, top bit negative)
          if (mx_sel[bit_r[4:0]]) begin
            if (bit_r == 5'd31)
              acc_r <= acc_r - ($signed({{34{mc_sel[31]}}, mc_sel}) <<< 31);
            else
              acc_r <= acc_r + ($signed({{34{mc_sel[31]}}, mc_sel}) <<< bit_r[4:0]);
          end
          if (bit_r == 5'd31) begin
            bit_r <= '0;
            if (mi_r == 3'd2 || mi_r == 3'd5) state_r <= S_LIN;
            else mi_r <= mi_r + 3'd1;
          end else begin
            bit_r <= bit_r + 5'd1;
          end
        end
        S_LIN: begin
          if (mi_r == 3'd2) begin
            lin_a_r <= sat(acc_r + 66'sd8388608);
            acc_r <= '0;
            mi_r <= 3'd3;
            state_r <= S_MUL;
          end else begin
            lin_r_r <= sat(acc_r + 66'sd8388608);
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          neg_r <= lin_r_r[31];
          abs_old_r <= rat_r[31] ? 32'(-rat_r) : rat_r;
          if ({1'b0, abs_lin} <= {2'b00, max_rate_r}) begin
            s_r <= {{32{lin_a_r[31]}}, lin_a_r};
            mode_r <= CASE_LINEAR;
            state_r <= S_DONE;
          end else if (((rat_r[31] ? 33'(-{rat_r[31], rat_r}) : {1'b0, rat_r}))
                       >= {2'b00, max_rate_r}) begin
            mode_r <= CASE_WHOLE;
            mcand_r <= {33'd0, max_rate_r};
            mplier_r <= {7'd0, step_r};
            acc_r <= '0;
            bit_r <= '0;
            state_r <= S_MAG;
          end else begin
            mode_r <= CASE_MID;
            mcand_r <= {33'd0, max_rate_r} -
                       {32'd0, (rat_r[31] ? 32'(-rat_r) : rat_r)};
            mplier_r <= {7'd0, step_r};
            acc_r <= '0;
            bit_r <= '0;
            mi_r <= '0;
            state_r <= S_MAG;
          end
        end
        S_MAG: begin
          if (mplier_r[bit_r[4:0]])
            acc_r <= acc_r + $signed({2'b00, mcand_r << bit_r[4:0]});
          if (bit_r == 5'd31) begin
            bit_r <= '0;
            if (mode_r == CASE_WHOLE) begin
              s_r <= 64'((acc_r + (mplier_r[31] ? $signed({2'b00, mcand_r << 31}) : 66'sd0)
                     + 66'sd8388608) >>> 24);
              state_r <= S_DONE;
            end else if (mi_r == 3'd0) begin
              // numerator ready; start divide
              num_r <= 64'(acc_r + (mplier_r[31] ? $signed({2'b00, mcand_r << 31}) : 66'sd0)
                       + $signed({34'd0, 32'(abs_lin - abs_old_r) >> 1}));
              den_r <= {32'd0, abs_lin - abs_old_r};
              rem_r <= '0;
              quo_r <= '0;
              dbit_r <= '0;
              state_r <= S_DIV;
            end else if (mi_r == 3'd1) begin
              s_r <= 64'(acc_r + (mplier_r[31] ? $signed({2'b00, mcand_r << 31}) : 66'sd0));
              mi_r <= 3'd2;
              mcand_r <= {32'd0, max_rate_r, 1'b0};
              mplier_r <= {7'd0, step_r - 25'(tacc_r)};
              acc_r <= '0;
            end else begin
              s_r <= 64'(($signed({2'b00, s_r}) + acc_r
                     + (mplier_r[31] ? $signed({2'b00, mcand_r << 31}) : 66'sd0)
                     + 66'sd16777216) >>> 25);
              state_r <= S_DONE;
            end
          end else begin
            bit_r <= bit_r + 5'd1;
          end
        end
        S_DIV: begin
          num_r <= num_r << 1;
          if (rem_sh >= {1'b0, den_r}) begin
            rem_r <= rem_sh - {1'b0, den_r};
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[62:0], 1'b0};
          end
          if (dbit_r == 6'd63) begin
            state_r <= S_MAG;
            mi_r <= 3'd1;
            bit_r <= '0;
            acc_r <= '0;
            mcand_r <= {32'd0, abs_old_r} + {33'd0, max_rate_r};
          end else begin
            dbit_r <= dbit_r + 6'd1;
          end
        end
        default: begin
          // S_DONE
          if (mode_r == CASE_LINEAR) begin
            if (lin_a_r < MIN_STEER_ANGLE) ang_r <= MIN_STEER_ANGLE;
            else if (lin_a_r > MAX_STEER_ANGLE) ang_r <= MAX_STEER_ANGLE;
            else ang_r <= lin_a_r;
            out_r.angle_out <= (lin_a_r < MIN_STEER_ANGLE) ? MIN_STEER_ANGLE :
                               (lin_a_r > MAX_STEER_ANGLE) ? MAX_STEER_ANGLE : lin_a_r;
            rat_r <= lin_r_r;
            out_r.rate_out <= lin_r_r;
          end else begin
            ang_r <= (newa < 34'(MIN_STEER_ANGLE)) ? MIN_STEER_ANGLE :
                     (newa > 34'(MAX_STEER_ANGLE)) ? MAX_STEER_ANGLE : newa[31:0];
            out_r.angle_out <= (newa < 34'(MIN_STEER_ANGLE)) ? MIN_STEER_ANGLE :
                     (newa > 34'(MAX_STEER_ANGLE)) ? MAX_STEER_ANGLE : newa[31:0];
            rat_r <= neg_r ? -$signed({1'b0, max_rate_r}) : $signed({1'b0, max_rate_r});
            out_r.rate_out <= neg_r ? -$signed({1'b0, max_rate_r})
                                    : $signed({1'b0, max_rate_r});
          end
          out_r.limit_case <= mode_r;
          out_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
      endcase
      if (state_r == S_DIV && dbit_r == 6'd63) begin
        tacc_r <= ({quo_r[62:0], (rem_sh >= {1'b0, den_r})} > {39'd0, step_r}) ?
                  {39'd0, step_r} : {quo_r[62:0], (rem_sh >= {1'b0, den_r})};
        mplier_r <= ({quo_r[62:0], (rem_sh >= {1'b0, den_r})} > {39'd0, step_r}) ?
                    {7'd0, step_r} : {quo_r[30:0], (rem_sh >= {1'b0, den_r})};
      end
    end
  end

endmodule

// File: tb/rate_limited_steering_actuator_step_test.sv
// ----------------------------------------------------------------------------
// rate_limited_steering_actuator_step_test
// Drives angle requests and register writes into the steering actuator step
// and checks every result word against a cycle-free model of the step:
// linear update, whole-step and mid-step rate limiting, and angle clamping.
// ----------------------------------------------------------------------------
module rate_limited_steering_actuator_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rlsa_pkg::*;

  localparam longint ONE = 64'sd16777216;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rlsa_if #(.word_t(in_word_t))  in_ch ();
  rlsa_if #(.word_t(out_word_t)) out_ch ();
  rlsa_if #(.word_t(cfg_word_t)) cfg_ch ();

  rate_limited_steering_actuator_step i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #10 clk = ~clk;

  // actuator model state and registers
  longint m_a11, m_a12, m_a21, m_a22, m_b1, m_b2, m_max_rate, m_step;
  longint m_angle, m_rate;

  out_word_t expected_steps[$];
  int errors = 0;
  int in_accepts = 0;
  int cfg_accepts = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  function automatic longint lin_comb(longint c1, longint x1, longint c2, longint x2,
                                      longint c3, longint x3);
    logic signed [67:0] p1, q1, p2, q2, p3, q3, acc;
    p1 = c1; q1 = x1; p2 = c2; q2 = x2; p3 = c3; q3 = x3;
    acc = p1 * q1 + p2 * q2 + p3 * q3;
    acc = (acc + 68'sd8388608) >>> 24;
    if (acc > 68'sd2147483647) return 64'sd2147483647;
    if (acc < -68'sd2147483648) return -64'sd2147483648;
    return longint'(acc);
  endfunction

  function automatic out_word_t predict_step(logic signed [31:0] req);
    longint la, lr, na, nr, lim, mag, abs_old, abs_lin, den, num, t_acc, t_con, s;
    logic [1:0] mode;
    out_word_t w;
    la = lin_comb(m_a11, m_angle, m_a12, m_rate, m_b1, longint'(req));
    lr = lin_comb(m_a21, m_angle, m_a22, m_rate, m_b2, longint'(req));
    lim = m_max_rate;
    abs_lin = lr < 0 ? -lr : lr;
    abs_old = m_rate < 0 ? -m_rate : m_rate;
    if (abs_lin <= lim) begin
      na = la;
      nr = lr;
      mode = CASE_LINEAR;
    end else begin
      if (abs_old >= lim) begin
        mag = (lim * m_step + 64'sd8388608) >> 24;
        mode = CASE_WHOLE;
      end else begin
        den = abs_lin - abs_old;
        num = (lim - abs_old) * m_step;
        t_acc = (num + den / 2) / den;
        if (t_acc > m_step) t_acc = m_step;
        t_con = m_step - t_acc;
        s = (abs_old + lim) * t_acc + 2 * lim * t_con;
        mag = (s + ONE) >> 25;
        mode = CASE_MID;
      end
      nr = lr < 0 ? -lim : lim;
      na = lr < 0 ? m_angle - mag : m_angle + mag;
    end
    if (na < longint'(MIN_STEER_ANGLE_DEF)) na = longint'(MIN_STEER_ANGLE_DEF);
    if (na > longint'(MAX_STEER_ANGLE_DEF)) na = longint'(MAX_STEER_ANGLE_DEF);
    m_angle = na;
    m_rate = longint'($signed(nr[31:0]));
    w.angle_out = na[31:0];
    w.rate_out = nr[31:0];
    w.limit_case = mode;
    return w;
  endfunction

  // acceptance monitors and result check, all sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      cycles <= cycles + 1;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (reg_idx_t'(cfg_ch.data.index))
          REG_A11:  m_a11 = longint'($signed(cfg_ch.data.data));
          REG_A12:  m_a12 = longint'($signed(cfg_ch.data.data));
          REG_A21:  m_a21 = longint'($signed(cfg_ch.data.data));
          REG_A22:  m_a22 = longint'($signed(cfg_ch.data.data));
          REG_B1:   m_b1 = longint'($signed(cfg_ch.data.data));
          REG_B2:   m_b2 = longint'($signed(cfg_ch.data.data));
          REG_RATE: m_max_rate = longint'({33'd0, cfg_ch.data.data[30:0]});
          REG_STEP: m_step = longint'({39'd0, cfg_ch.data.data[24:0]});
          default: ;
        endcase
        cfg_accepts++;
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_steps = {expected_steps, predict_step(in_ch.data.angle_request)};
        in_accepts++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_steps.size() == 0) begin
          $display("%0t unexpected word: expected none actual %h", $time, out_ch.data);
          errors++;
        end else begin
          out_word_t e;
          e = expected_steps.pop_front();
          if (out_ch.data.angle_out !== e.angle_out) begin
            $display("%0t angle_out: expected %0d actual %0d", $time,
                     e.angle_out, out_ch.data.angle_out);
            errors++;
          end
          if (out_ch.data.rate_out !== e.rate_out) begin
            $display("%0t rate_out: expected %0d actual %0d", $time,
                     e.rate_out, out_ch.data.rate_out);
            errors++;
          end
          if (out_ch.data.limit_case !== e.limit_case) begin
            $display("%0t limit_case: expected %0d actual %0d", $time,
                     e.limit_case, out_ch.data.limit_case);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (stall_left > 0) begin
      rdy = 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rdy = 1'b0;
      stall_left = $urandom_range(0, 4);
    end
    out_ch.ready <= rdy;
  end

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 5)) @(negedge clk);
  endtask

  task automatic send_request(logic signed [31:0] req);
    int n0;
    idle_gap();
    n0 = in_accepts;
    in_ch.data.angle_request = req;
    in_ch.valid = 1'b1;
    do @(negedge clk); while (in_accepts == n0);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    int n0;
    n0 = cfg_accepts;
    cfg_ch.data.index = idx;
    cfg_ch.data.data = value;
    cfg_ch.valid = 1'b1;
    do @(negedge clk); while (cfg_accepts == n0);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (expected_steps.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic load_all(longint a11, longint a12, longint a21, longint a22,
                          longint b1, longint b2, longint rate, longint step);
    write_reg(REG_A11, a11[31:0]);
    write_reg(REG_A12, a12[31:0]);
    write_reg(REG_A21, a21[31:0]);
    write_reg(REG_A22, a22[31:0]);
    write_reg(REG_B1, b1[31:0]);
    write_reg(REG_B2, b2[31:0]);
    write_reg(REG_RATE, rate[31:0]);
    write_reg(REG_STEP, step[31:0]);
  endtask

  function automatic logic signed [31:0] near_request();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $signed($urandom_range(0, 33554432)) - 32'sd16777216;
  endfunction

  task automatic test_reset_defaults();
    send_request(32'sh7FFFFFFF);
    send_request(-32'sh80000000);
    send_request(32'sd0);
    send_request(-32'sd1);
    drain();
  endtask

  // rate follows request directly, limit of 1.0
  task automatic test_limit_cases();
    load_all(ONE, 0, 0, 0, 0, ONE, ONE, 167772);
    send_request(32'sd16777216);             // exactly at limit
    send_request(32'sd16777316);             // old rate already at limit
    send_request(32'sd0);
    send_request(32'sd33554432);             // reached mid-step
    send_request(-32'sd33554432);
    send_request(32'sh7FFFFFFF);
    send_request(-32'sh80000000);
    drain();
    write_reg(REG_STEP, 32'd0);              // zero step time
    send_request(32'sd0);
    send_request(32'sd50331648);
    send_request(32'sd50331648);
    drain();
    write_reg(REG_STEP, 32'd16777216);
    write_reg(REG_RATE, 32'd0);              // zero rate limit
    send_request(32'sd5);
    send_request(-32'sd5);
    send_request(32'sd0);
    drain();
    load_all(ONE, 0, 0, ONE, ONE, 0, 32'h7FFFFFFF, 32'h01FFFFFF);
    send_request(32'sh7FFFFFFF);             // angle clamps high
    send_request(32'sd1);
    send_request(-32'sh80000000);            // and low
    send_request(-32'sd1);
    drain();
  endtask

  task automatic test_random_phase(bit noise, int items);
    if (noise)
      load_all($signed($urandom), $signed($urandom), $signed($urandom),
               $signed($urandom), $signed($urandom), $signed($urandom),
               $urandom & 32'h7FFFFFFF, $urandom_range(0, 16777216));
    else
      load_all(ONE + $urandom_range(0, 65536), $urandom_range(0, 1048576),
               -longint'($urandom_range(0, 4194304)), ONE - $urandom_range(0, 4194304),
               $urandom_range(0, 1048576), $urandom_range(0, 8388608),
               $urandom_range(0, 67108864),
               ($urandom_range(0, 7) == 0) ? 16777216 : $urandom_range(1, 1677722));
    repeat (items) send_request(noise ? $signed($urandom) : near_request());
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    m_a11 = ONE; m_a12 = 0; m_a21 = 0; m_a22 = ONE; m_b1 = 0; m_b2 = 0;
    m_max_rate = 167772160; m_step = 167772;
    m_angle = 0; m_rate = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_limit_cases();
    test_random_phase(1'b0, 150);
    test_random_phase(1'b1, 120);
    test_random_phase(1'b0, 150);
    test_random_phase(1'b1, 100);
    test_random_phase(1'b0, 150);
    quiet = 1'b1;
    test_random_phase(1'b0, 150);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/rlsa_pkg.sv
hw/rtl/rlsa_if.sv
hw/rtl/rate_limited_steering_actuator_step.sv
tb/rate_limited_steering_actuator_step_test.sv
